FILE: rtl/tagged_lru_lookup_cache_core_assert.svh
// assertion macros for the tagged lru lookup cache
`ifndef TAGGED_LRU_LOOKUP_CACHE_CORE_ASSERT_SVH
`define TAGGED_LRU_LOOKUP_CACHE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TLC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tlc assertion failed");
`define TLC_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tlc assertion failed");
`else
`define TLC_ASSERT(label, clk, rst_n, prop)
`define TLC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: rtl/tlc_pkg.sv
// shared types and constants of the tagged lru lookup cache
`timescale 1ns / 1ps
package tlc_pkg;
	localparam int ENTRIES = 128;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_W = 7;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_FILL = 1'b1;

	typedef logic [127:0] tag_t;
	typedef logic [63:0] stamp_t;

	localparam stamp_t EMPTY_STAMP = 64'd1;
	localparam stamp_t CNT_RESET = 64'd2;

	typedef struct packed {
		logic cmd;
		logic [63:0] tag_hi;
		logic [63:0] tag_lo;
		logic [63:0] fill_rights_hi;
		logic [63:0] fill_rights_lo;
		logic [7:0] fill_key_gen;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [63:0] rights_hi;
		logic [63:0] rights_lo;
		logic [7:0] key_gen;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	typedef struct packed {
		logic [63:0] tag_hi;
		logic [63:0] tag_lo;
		logic [63:0] rights_hi;
		logic [63:0] rights_lo;
		logic [7:0] key_gen;
	} entry_t;

	typedef struct packed {
		logic start;
		logic vld;
		logic cmd;
		logic [IDX_W-1:0] idx;
		logic ent_vld;
	} scan_ctl_t;

	typedef struct packed {
		logic found;
		logic [IDX_W-1:0] idx;
	} scan_res_t;
endpackage

FILE: rtl/tlc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tlc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/tlc_scan.sv
// shared tag and stamp compare unit with candidate tracking
`timescale 1ns / 1ps
module tlc_scan (
	input logic clk,
	input logic arst_n,
	input tlc_pkg::scan_ctl_t ctl,
	input tlc_pkg::tag_t req_tag,
	input tlc_pkg::tag_t ram_tag,
	input tlc_pkg::stamp_t ram_stamp,
	output tlc_pkg::scan_res_t res
);
	import tlc_pkg::*;

	logic found_q;
	logic [IDX_W-1:0] idx_q;
	logic match_q;
	stamp_t stamp_q;

	tag_t eff_tag;
	stamp_t eff_stamp;
	logic match;
	logic lower;
	logic nonempty;
	logic first;
	logic hit_take;
	logic fill_take;

	// entries never written read as cleared
	always_comb begin
		eff_tag = ctl.ent_vld ? ram_tag : '0;
		eff_stamp = ctl.ent_vld ? ram_stamp : EMPTY_STAMP;
		match = (eff_tag == req_tag);
		lower = (eff_stamp < stamp_q);
		nonempty = (eff_stamp != EMPTY_STAMP);
		first = (ctl.idx == '0);
		hit_take = ctl.vld && (ctl.cmd == CMD_LOOKUP) && !found_q && match && nonempty;
		fill_take = ctl.vld && (ctl.cmd == CMD_FILL) && (first || match || (!match_q && lower));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (hit_take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_take) begin
			idx_q <= ctl.idx;
		end else if (fill_take) begin
			idx_q <= ctl.idx;
			match_q <= match;
			stamp_q <= eff_stamp;
		end
	end

	assign res = '{found: found_q, idx: idx_q};
endmodule

FILE: rtl/tagged_lru_lookup_cache_core.sv
// Fully associative tag cache with timestamp lru, scanned by one compare unit.
// A request is taken in ST_IDLE; ST_SCAN reads every entry in turn, then ST_LAST, ST_UPDATE,
// ST_READ for a lookup hit only (extra entry ram read), and ST_RESP, which loads rsp_valid.
// A new word is taken only after the previous one has left ST_RESP, so ram scans never overlap.
// Reset: valid bits cleared so every entry reads empty, use counter set to 2;
// no clearing pass, a word is taken in the first cycle after reset.
`timescale 1ns / 1ps
`include "tagged_lru_lookup_cache_core_assert.svh"
module tagged_lru_lookup_cache_core (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input tlc_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output tlc_pkg::rsp_t rsp
);
	import tlc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_UPDATE,
		ST_READ,
		ST_RESP
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] addr_q;
	logic scan_vld_s1;
	logic rsp_valid_q;
	stamp_t cnt_q;
	logic [ENTRIES-1:0] valid_q;

	req_t req_q;
	logic [IDX_W-1:0] idx_s1;
	logic ent_vld_s1;
	rsp_t res_q;
	rsp_t rsp_q;

	logic accept;
	logic out_free;
	logic [IDX_W-1:0] raddr;
	entry_t ent_rdata;
	entry_t ent_wdata;
	stamp_t stamp_rdata;
	logic ent_we;
	logic stamp_we;
	scan_ctl_t scan_ctl;
	scan_res_t scan_res;

	assign accept = (state_q == ST_IDLE) && req_valid;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign raddr = (state_q == ST_SCAN) ? addr_q : scan_res.idx;
	assign ent_we = (state_q == ST_UPDATE) && (req_q.cmd == CMD_FILL);
	assign stamp_we = (state_q == ST_UPDATE) && ((req_q.cmd == CMD_FILL) || scan_res.found);
	assign ent_wdata = '{tag_hi: req_q.tag_hi, tag_lo: req_q.tag_lo,
		rights_hi: req_q.fill_rights_hi, rights_lo: req_q.fill_rights_lo,
		key_gen: req_q.fill_key_gen};

	assign scan_ctl = '{start: accept, vld: scan_vld_s1, cmd: req_q.cmd, idx: idx_s1,
		ent_vld: ent_vld_s1};

	tlc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk(clk),
		.we(ent_we),
		.waddr(scan_res.idx),
		.wdata(ent_wdata),
		.raddr(raddr),
		.rdata(ent_rdata)
	);

	tlc_ram #(
		.WIDTH($bits(stamp_t)),
		.DEPTH(ENTRIES)
	) u_stamp_ram (
		.clk(clk),
		.we(stamp_we),
		.waddr(scan_res.idx),
		.wdata(cnt_q),
		.raddr(raddr),
		.rdata(stamp_rdata)
	);

	tlc_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(scan_ctl),
		.req_tag({req_q.tag_hi, req_q.tag_lo}),
		.ram_tag({ent_rdata.tag_hi, ent_rdata.tag_lo}),
		.ram_stamp(stamp_rdata),
		.res(scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q <= '0;
			scan_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			cnt_q <= CNT_RESET;
			valid_q <= '0;
		end else begin
			scan_vld_s1 <= (state_q == ST_SCAN);
			if ((state_q == ST_RESP) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						addr_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_IDX) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (req_q.cmd == CMD_FILL) begin
						valid_q[scan_res.idx] <= 1'b1;
						cnt_q <= cnt_q + 64'd1;
						state_q <= ST_RESP;
					end else if (scan_res.found) begin
						cnt_q <= cnt_q + 64'd1;
						state_q <= ST_READ;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s1 <= addr_q;
		ent_vld_s1 <= valid_q[addr_q];
		if (state_q == ST_UPDATE) begin
			if (req_q.cmd == CMD_FILL) begin
				res_q <= '{hit: 1'b1, rights_hi: req_q.fill_rights_hi,
					rights_lo: req_q.fill_rights_lo, key_gen: req_q.fill_key_gen,
					slot: SLOT_W'(scan_res.idx)};
			end else begin
				res_q <= '0;
			end
		end
		if (state_q == ST_READ) begin
			res_q <= '{hit: 1'b1, rights_hi: ent_rdata.rights_hi,
				rights_lo: ent_rdata.rights_lo, key_gen: ent_rdata.key_gen,
				slot: SLOT_W'(scan_res.idx)};
		end
		if ((state_q == ST_RESP) && out_free) begin
			rsp_q <= res_q;
		end
	end

	`TLC_ASSERT(a_cnt_step, clk, arst_n, cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + 64'd1 && $past(state_q) == ST_UPDATE)
	`TLC_ASSERT(a_valid_grow, clk, arst_n, $countones(valid_q) >= $countones($past(valid_q)))
	`TLC_ASSERT(a_rsp_load, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q) == ST_RESP)
	`TLC_ASSERT_NEVER(a_miss_zero, clk, arst_n, rsp_valid_q && !rsp_q.hit && (rsp_q.rights_hi != 64'd0 || rsp_q.rights_lo != 64'd0 || rsp_q.key_gen != 8'd0))
endmodule

FILE: tb/tagged_lru_lookup_cache_core_checker.sv
// checker that predicts the cache responses and compares them with the block
`timescale 1ns / 1ps
module tagged_lru_lookup_cache_core_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input tlc_pkg::req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input tlc_pkg::rsp_t rsp,
	output int mismatches,
	output int results_owed
);
	import tlc_pkg::*;

	tag_t tag_mem [ENTRIES];
	logic [63:0] rights_hi_mem [ENTRIES];
	logic [63:0] rights_lo_mem [ENTRIES];
	logic [7:0] key_gen_mem [ENTRIES];
	stamp_t stamp_mem [ENTRIES];
	stamp_t use_ctr;
	rsp_t owed_rsp_q [$];
	rsp_t owed_rsp;

	function automatic rsp_t access_cache(input req_t w);
		tag_t t;
		int idx;
		rsp_t r;
		t = {w.tag_hi, w.tag_lo};
		r = '0;
		if (w.cmd == CMD_LOOKUP) begin
			idx = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (idx < 0 && stamp_mem[i] != EMPTY_STAMP && tag_mem[i] == t) begin
					idx = i;
				end
			end
			if (idx < 0) begin
				return r;
			end
		end else begin
			idx = 0;
			// a matching tag always wins, otherwise the older stamp
			for (int i = 1; i < ENTRIES; i++) begin
				if (tag_mem[i] == t || (tag_mem[idx] != t && stamp_mem[i] < stamp_mem[idx])) begin
					idx = i;
				end
			end
			tag_mem[idx] = t;
			rights_hi_mem[idx] = w.fill_rights_hi;
			rights_lo_mem[idx] = w.fill_rights_lo;
			key_gen_mem[idx] = w.fill_key_gen;
		end
		stamp_mem[idx] = use_ctr;
		use_ctr = use_ctr + 64'd1;
		r.hit = 1'b1;
		r.rights_hi = rights_hi_mem[idx];
		r.rights_lo = rights_lo_mem[idx];
		r.key_gen = key_gen_mem[idx];
		r.slot = SLOT_W'(idx);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				tag_mem[i] = '0;
				rights_hi_mem[i] = '0;
				rights_lo_mem[i] = '0;
				key_gen_mem[i] = '0;
				stamp_mem[i] = EMPTY_STAMP;
			end
			use_ctr = CNT_RESET;
			owed_rsp_q.delete();
			results_owed = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsp_q.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual %h", $time, rsp);
					mismatches++;
				end else begin
					owed_rsp = owed_rsp_q.pop_front();
					check_field("hit", owed_rsp.hit, rsp.hit);
					check_field("rights_hi", owed_rsp.rights_hi, rsp.rights_hi);
					check_field("rights_lo", owed_rsp.rights_lo, rsp.rights_lo);
					check_field("key_gen", owed_rsp.key_gen, rsp.key_gen);
					check_field("slot", owed_rsp.slot, rsp.slot);
				end
			end
			if (req_valid && !req_stall) begin
				owed_rsp_q.push_back(access_cache(req));
			end
			results_owed = owed_rsp_q.size();
		end
	end
endmodule

FILE: tb/tagged_lru_lookup_cache_core_tb.sv
// testbench top: stimulus, handshake idling and verdict for the lru tag cache
`timescale 1ns / 1ps
module tagged_lru_lookup_cache_core_tb;
	import tlc_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 700;
	localparam int PAUSE_AT = 500;
	localparam int RANDOM_WORDS = 1090;
	localparam int POOL_SIZE = 192;
	localparam int HOT_SIZE = 32;
	localparam int DRAIN_CYCLES = 150;
	localparam logic [63:0] ALT = 64'hAAAA_AAAA_AAAA_AAAA;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int mismatches;
	int results_owed;
	int idle_cycles = 0;
	int words_received = 0;
	logic sender_eager = 1'b0;
	tag_t tag_pool [POOL_SIZE];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tagged_lru_lookup_cache_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	tagged_lru_lookup_cache_core_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.mismatches(mismatches),
		.results_owed(results_owed)
	);

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_req(input logic c, input tag_t t, input logic [127:0] rights,
		input logic [7:0] kg);
		req_t w;
		int unsigned gap;
		w.cmd = c;
		w.tag_hi = t[127:64];
		w.tag_lo = t[63:0];
		w.fill_rights_hi = rights[127:64];
		w.fill_rights_lo = rights[63:0];
		w.fill_key_gen = kg;
		gap = sender_eager ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		tag_t t;
		int unsigned roll;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		tag_pool[0] = '0;
		for (int i = 1; i < POOL_SIZE; i++) begin
			tag_pool[i] = {rand64(), rand64()};
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty cache, zero tag matching empty slots, overwrite, half-matching tags
		send_req(CMD_LOOKUP, '0, '0, 8'h00);
		send_req(CMD_LOOKUP, '1, '0, 8'h00);
		send_req(CMD_FILL, '0, '1, 8'hFF);
		send_req(CMD_LOOKUP, '0, '0, 8'h00);
		send_req(CMD_FILL, '1, '0, 8'h00);
		send_req(CMD_LOOKUP, '1, '1, 8'hFF);
		send_req(CMD_FILL, '1, {ALT, ~ALT}, 8'h80);
		send_req(CMD_LOOKUP, '1, '0, 8'h00);
		send_req(CMD_LOOKUP, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, '0, 8'h00);
		send_req(CMD_LOOKUP, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, '0, 8'h00);
		send_req(CMD_FILL, {ALT, ~ALT}, {~ALT, ALT}, 8'h5A);
		send_req(CMD_FILL, {~ALT, ALT}, {ALT, ~ALT}, 8'hA5);
		send_req(CMD_LOOKUP, {ALT, ~ALT}, '0, 8'h00);
		send_req(CMD_LOOKUP, {~ALT, ALT}, '1, 8'hFF);
		send_req(CMD_FILL, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, '1, 8'h01);
		send_req(CMD_LOOKUP, '0, '0, 8'h00);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == PAUSE_AT) begin
				req_valid <= 1'b0;
				@(negedge clk);
				while (results_owed != 0) @(negedge clk);
			end
			sender_eager = (n >= 400 && n < 480);
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				t = {rand64(), rand64()};
			end else if (roll < 55) begin
				t = tag_pool[$urandom_range(0, HOT_SIZE - 1)];
			end else begin
				t = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
			end
			send_req(($urandom_range(0, 99) < 40) ? CMD_FILL : CMD_LOOKUP, t,
				{rand64(), rand64()}, 8'($urandom));
		end
		req_valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && results_owed == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		int unsigned gap;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (words_received == HOLD_AT) begin
				gap = HOLD_CYCLES;
			end else if (words_received >= 600 && words_received < 680) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 4);
			end
			if (gap != 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			words_received++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end
endmodule
